>>> rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Types, constants and hash helpers shared by the record frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package rfd_pkg;

  localparam int unsigned HEADER_BYTES    = 10;
  localparam int unsigned KEYSTREAM_BYTES = 32;
  localparam int unsigned POS_W           = 17;
  localparam int unsigned KS_IDX_W        = $clog2(KEYSTREAM_BYTES);
  localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_HDR    = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST_HDR = POS_W'(HEADER_BYTES - 1);
  // Bit length of the key || nonce message.
  localparam logic [31:0] MSG_BITS        = 32'd64;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_MAGIC1 = 3'd2;
  localparam logic [2:0] ST_MAGIC2 = 3'd3;
  localparam logic [2:0] ST_LENGTH = 3'd4;
  localparam logic [2:0] ST_EMPTY  = 3'd5;
  localparam logic [2:0] ST_CHKSUM = 3'd6;

  // Queue entry kinds.
  localparam logic [1:0] KIND_END  = 2'd0;  // last byte inside the header
  localparam logic [1:0] KIND_HASH = 2'd1;  // header complete, derive keystream
  localparam logic [1:0] KIND_PAY  = 2'd2;  // payload byte

  // Configuration register indexes.
  localparam logic [1:0] REG_DECRYPT_KEY = 2'd0;
  localparam logic [1:0] REG_PASS_KEY    = 2'd1;
  localparam logic [1:0] REG_MAGIC1      = 2'd2;
  localparam logic [1:0] REG_MAGIC2      = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } rfd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       record_done;
    logic [2:0] status;
  } rfd_out_t;

  typedef struct packed {
    logic [31:0] decrypt_key;
    logic [31:0] passthrough_key;
    logic [7:0]  first_magic;
    logic [7:0]  second_magic;
  } rfd_cfg_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          data;
    logic                last;
    logic [KS_IDX_W-1:0] ks_idx;
    logic                zero_ks;
    logic [2:0]          pre_status;
    logic [31:0]         aux;      // nonce for a hash entry, checksum for payload
  } rfd_entry_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/rfd_queue.sv
// ----------------------------------------------------------------------------
// rfd_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module rfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  rfd_pkg::rfd_entry_t push_entry,
  input  wire                 pop,
  output rfd_pkg::rfd_entry_t head,
  output logic                empty,
  output logic                full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rfd_pkg::rfd_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/rfd_front.sv
// ----------------------------------------------------------------------------
// rfd_front
// Accepts record bytes, parses the header and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none
module rfd_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rfd_pkg::rfd_cfg_t   cfg,
  input  wire                 in_valid,
  output logic                in_stall,
  input  rfd_pkg::rfd_in_t    in_data,
  input  wire                 q_full,
  output logic                push,
  output rfd_pkg::rfd_entry_t push_entry
);

  logic [rfd_pkg::POS_W-1:0] pos_r, pos_inc, pay_off;
  logic [15:0] chk_r, chk_nxt;
  logic [31:0] nonce_r, nonce_nxt;
  logic [15:0] len_r, len_nxt;
  logic [2:0]  herr_r, herr_nxt;
  logic        accept, in_hdr, hdr_end;
  logic [7:0]  b;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign b        = in_data.in_byte;
  assign in_hdr   = (pos_r < rfd_pkg::POS_HDR);
  assign hdr_end  = (pos_r == rfd_pkg::POS_LAST_HDR);
  assign pos_inc  = (pos_r == rfd_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
  assign pay_off  = pos_r - rfd_pkg::POS_HDR;

  always_comb begin
    chk_nxt   = chk_r;
    nonce_nxt = nonce_r;
    len_nxt   = len_r;
    herr_nxt  = herr_r;
    if (in_hdr) begin
      case (pos_r[3:0])
        4'd0: if (b != cfg.first_magic) herr_nxt = rfd_pkg::ST_MAGIC1;
        4'd1: chk_nxt = {b, chk_r[7:0]};
        4'd2: chk_nxt = {chk_r[15:8], b};
        4'd3: nonce_nxt = {b, nonce_r[23:0]};
        4'd4: nonce_nxt = {nonce_r[31:24], b, nonce_r[15:0]};
        4'd5: nonce_nxt = {nonce_r[31:16], b, nonce_r[7:0]};
        4'd6: nonce_nxt = {nonce_r[31:8], b};
        4'd7: len_nxt = {b, len_r[7:0]};
        4'd8: len_nxt = {len_r[15:8], b};
        default: begin
          if (b != cfg.second_magic && herr_r == rfd_pkg::ST_OK) begin
            herr_nxt = rfd_pkg::ST_MAGIC2;
          end
        end
      endcase
    end
  end

  always_comb begin
    push_entry         = '0;
    push_entry.data    = b;
    push_entry.last    = in_data.last_byte;
    push_entry.ks_idx  = pay_off[rfd_pkg::KS_IDX_W-1:0];
    push_entry.zero_ks = (cfg.decrypt_key == cfg.passthrough_key);
    if (!in_hdr) begin
      push_entry.kind = rfd_pkg::KIND_PAY;
      push_entry.aux  = {16'd0, chk_r};
    end else if (hdr_end) begin
      push_entry.kind = rfd_pkg::KIND_HASH;
      push_entry.aux  = nonce_r;
    end else begin
      push_entry.kind = rfd_pkg::KIND_END;
    end
    // Leave ST_OK for the back end to settle against the checksum.
    if (pos_inc < rfd_pkg::POS_HDR) begin
      push_entry.pre_status = rfd_pkg::ST_SHORT;
    end else if (herr_nxt != rfd_pkg::ST_OK) begin
      push_entry.pre_status = herr_nxt;
    end else if ((pos_inc - rfd_pkg::POS_HDR) != {1'b0, len_r}) begin
      push_entry.pre_status = rfd_pkg::ST_LENGTH;
    end else if (pos_inc == rfd_pkg::POS_HDR) begin
      push_entry.pre_status = rfd_pkg::ST_EMPTY;
    end else begin
      push_entry.pre_status = rfd_pkg::ST_OK;
    end
    if (!in_data.last_byte) begin
      push_entry.pre_status = rfd_pkg::ST_OK;
    end
  end

  assign push = accept && (!in_hdr || hdr_end || in_data.last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      herr_r  <= rfd_pkg::ST_OK;
      chk_r   <= '0;
      nonce_r <= '0;
      len_r   <= '0;
    end else if (accept) begin
      chk_r   <= chk_nxt;
      nonce_r <= nonce_nxt;
      len_r   <= len_nxt;
      if (in_data.last_byte) begin
        pos_r  <= '0;
        herr_r <= rfd_pkg::ST_OK;
      end else begin
        pos_r  <= pos_inc;
        herr_r <= herr_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/rfd_back.sv
// ----------------------------------------------------------------------------
// rfd_back
// Runs the keystream hash, decrypts payload items and reports status.
// ----------------------------------------------------------------------------
`default_nettype none
module rfd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rfd_pkg::rfd_cfg_t   cfg,
  input  rfd_pkg::rfd_entry_t head,
  input  wire                 q_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output rfd_pkg::rfd_out_t   out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  rnd_r;
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] ks_r [8];
  logic        zero_r;
  logic [15:0] sum_r;
  logic        pend_last_r;
  logic [2:0]  pend_status_r;
  logic        out_valid_r;
  rfd_pkg::rfd_out_t out_r;

  logic        out_free, load_out;
  rfd_pkg::rfd_out_t out_nxt;
  logic [31:0] t1, t2, w_new, ks_word;
  logic [7:0]  ks_byte, ob;
  logic [15:0] sum_add;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign t1 = v_r[7] + rfd_pkg::big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + rfd_pkg::round_k(rnd_r) + w_r[0];
  assign t2 = rfd_pkg::big_sig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = w_r[0] + rfd_pkg::sml_sig0(w_r[1]) + w_r[9] + rfd_pkg::sml_sig1(w_r[14]);

  assign ks_word = ks_r[head.ks_idx[4:2]];
  always_comb begin
    case (head.ks_idx[1:0])
      2'd0:    ks_byte = ks_word[31:24];
      2'd1:    ks_byte = ks_word[23:16];
      2'd2:    ks_byte = ks_word[15:8];
      default: ks_byte = ks_word[7:0];
    endcase
    if (zero_r) ks_byte = 8'd0;
  end
  assign ob      = head.data ^ ks_byte;
  assign sum_add = sum_r + {8'd0, ob};

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    out_nxt   = '0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          if (head.kind == rfd_pkg::KIND_HASH) begin
            pop = 1'b1;
            if (!head.zero_ks) begin
              state_nxt = S_HASH;
            end else if (head.last) begin
              state_nxt = S_EMIT;
            end
          end else if (out_free) begin
            pop                 = 1'b1;
            load_out            = 1'b1;
            out_nxt.record_done = head.last;
            if (head.kind == rfd_pkg::KIND_PAY) begin
              out_nxt.out_byte   = ob;
              out_nxt.byte_valid = 1'b1;
              if (head.last) begin
                if (head.pre_status != rfd_pkg::ST_OK) begin
                  out_nxt.status = head.pre_status;
                end else if (sum_add != head.aux[15:0]) begin
                  out_nxt.status = rfd_pkg::ST_CHKSUM;
                end
              end
            end else begin
              out_nxt.status = head.pre_status;
            end
          end
        end
      end
      S_HASH: if (rnd_r == 6'd63) state_nxt = S_FIN;
      S_FIN:  state_nxt = pend_last_r ? S_EMIT : S_IDLE;
      default: begin
        if (out_free) begin
          load_out            = 1'b1;
          out_nxt.record_done = 1'b1;
          out_nxt.status      = pend_status_r;
          state_nxt           = S_IDLE;
        end
      end
    endcase
  end

  // Hash datapath and keystream store
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop && head.kind == rfd_pkg::KIND_HASH) begin
      zero_r        <= head.zero_ks;
      pend_last_r   <= head.last;
      pend_status_r <= head.pre_status;
      rnd_r         <= '0;
      for (int i = 0; i < 8; i++) v_r[i] <= rfd_pkg::init_h(3'(i));
      for (int i = 3; i < 15; i++) w_r[i] <= '0;
      w_r[0]  <= rfd_pkg::swap32(cfg.decrypt_key);
      w_r[1]  <= rfd_pkg::swap32(head.aux);
      w_r[2]  <= 32'h8000_0000;
      w_r[15] <= rfd_pkg::MSG_BITS;
    end else if (state_r == S_HASH) begin
      rnd_r  <= rnd_r + 1'b1;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end else if (state_r == S_FIN) begin
      for (int i = 0; i < 8; i++) ks_r[i] <= rfd_pkg::init_h(3'(i)) + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Restart the sum at each record end.
      if (load_out && out_nxt.record_done) begin
        sum_r <= '0;
      end else if (load_out && out_nxt.byte_valid) begin
        sum_r <= sum_add;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/record_frame_decoder.sv
// ----------------------------------------------------------------------------
// record_frame_decoder
// Header parsing, keystream derivation and payload decryption of records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one record byte per item
//   with a flag on the last byte. Output channel out_valid/out_stall/out_data
//   gives one item per payload byte and one for the record's last byte; header
//   bytes other than a record's last produce nothing.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 decrypt
//   key, 1 passthrough key, 2 first magic, 3 second magic); write only idle.
//   Throughput: one payload byte per cycle while no output item is held by
//   out_stall and no keystream is being derived. After the tenth header
//   byte the back end runs 64 hash rounds on one round unit plus a finalise
//   step to derive the keystream; with the passthrough key this is skipped.
//   A payload item's result passes the queue write, then the output register.
//   The front end keeps accepting until the queue of QUEUE_DEPTH items fills,
//   then raises in_stall. While out_stall holds an item, it stays and the
//   back end takes no further items that give output from the queue.
//   Reset (rst_n low, synchronous) clears configuration, control state,
//   position and queue; the next byte starts a new record.
// ----------------------------------------------------------------------------
`default_nettype none
module record_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire [1:0]         cfg_index,
  input  wire [31:0]        cfg_data,
  input  wire               in_valid,
  output logic              in_stall,
  input  rfd_pkg::rfd_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output rfd_pkg::rfd_out_t out_data
);

  rfd_pkg::rfd_cfg_t   cfg_r;
  rfd_pkg::rfd_entry_t push_entry, head;
  logic push, pop, q_empty, q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfd_pkg::REG_DECRYPT_KEY: cfg_r.decrypt_key     <= cfg_data;
        rfd_pkg::REG_PASS_KEY:    cfg_r.passthrough_key <= cfg_data;
        rfd_pkg::REG_MAGIC1:      cfg_r.first_magic     <= cfg_data[7:0];
        rfd_pkg::REG_MAGIC2:      cfg_r.second_magic    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify
  rfd_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_full(q_full), .push(push), .push_entry(push_entry)
  );

  // Queue between the two halves
  rfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_entry(push_entry),
    .pop(pop), .head(head), .empty(q_empty), .full(q_full)
  );

  // Back end: hash, decrypt, report
  rfd_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .q_empty(q_empty),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Status is only reported on a record end.
  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.record_done |-> out_data.status == rfd_pkg::ST_OK)
    else $error("status set on an item that does not end a record");

  // An item without a payload byte must end a record with a fault.
  a_no_byte_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |->
      out_data.record_done && out_data.status != rfd_pkg::ST_OK &&
      out_data.out_byte == 8'd0)
    else $error("empty item that is not a faulty record end");

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into a full queue");

endmodule
`default_nettype wire
